>>> sv/b64lw_pkg.sv
// Shared types, constants and the alphabet mapping for the line-wrapped base64 encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package b64lw_pkg;

	// character codes
	localparam logic [6:0] CHAR_PAD = 7'd61;
	localparam logic [6:0] CHAR_CR  = 7'd13;
	localparam logic [6:0] CHAR_LF  = 7'd10;

	// groups per line after reset
	localparam logic [7:0] GPL_RESET = 8'd18;

	// character slots within one job
	localparam logic [2:0] SLOT_FIRST = 3'd0;
	localparam logic [2:0] SLOT_G3    = 3'd3;
	localparam logic [2:0] SLOT_CR    = 3'd4;
	localparam logic [2:0] SLOT_LF    = 3'd5;

	// one job: a four-character group, an optional CR LF, end-of-message mark
	typedef struct packed {
		logic [3:0][6:0] chars;
		logic            newline;
		logic            msg_last;
	} job_t;

	// six-bit value to standard alphabet character
	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] w;
		w = {1'b0, v};
		if (v < 6'd26) begin
			b64_char = w + 7'd65;
		end else if (v < 6'd52) begin
			b64_char = w + 7'd71;
		end else if (v < 6'd62) begin
			b64_char = w - 7'd4;
		end else if (v == 6'd62) begin
			b64_char = 7'd43;
		end else begin
			b64_char = 7'd47;
		end
	endfunction

endpackage

`default_nettype wire

>>> sv/b64lw_front.sv
// Front end: accepts bytes, keeps pending bytes and line count, builds jobs.
// Depends on b64lw_pkg.
`default_nettype none

module b64lw_front
	import b64lw_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       message_last,
	input  wire logic       q_full,
	output logic            push,
	output job_t            push_job
);

	logic [7:0]  gpl_q;
	logic [15:0] pend_q;
	logic [1:0]  cnt_q;
	logic [7:0]  gil_q;

	logic        accept;
	logic        full_grp;
	logic        emit;
	logic [7:0]  limit;
	logic [7:0]  b0, b1, b2;
	logic [7:0]  gil_inc;
	logic [7:0]  gil_after;
	logic        wrap_nl;
	logic        two_bytes;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// group classification
	always_comb begin
		limit     = (gpl_q == 8'd0) ? 8'd1 : gpl_q;
		full_grp  = (cnt_q == 2'd2);
		emit      = full_grp || message_last;
		two_bytes = (cnt_q == 2'd1);
		if (full_grp) begin
			b0 = pend_q[15:8];
			b1 = pend_q[7:0];
			b2 = data_byte;
		end else if (two_bytes) begin
			b0 = pend_q[15:8];
			b1 = data_byte;
			b2 = 8'd0;
		end else begin
			b0 = data_byte;
			b1 = 8'd0;
			b2 = 8'd0;
		end
		gil_inc   = gil_q + 8'd1;
		wrap_nl   = full_grp && (gil_inc >= limit);
		gil_after = wrap_nl ? 8'd0 : gil_inc;
	end

	// job payload
	always_comb begin
		push_job.chars[0] = b64_char(b0[7:2]);
		push_job.chars[1] = b64_char({b0[1:0], b1[7:4]});
		push_job.chars[2] = (full_grp || two_bytes) ? b64_char({b1[3:0], b2[7:6]}) : CHAR_PAD;
		push_job.chars[3] = full_grp ? b64_char(b2[5:0]) : CHAR_PAD;
		push_job.newline  = wrap_nl || (message_last && (gil_after != 8'd0));
		push_job.msg_last = message_last;
		push              = accept && emit;
	end

	// line length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpl_q <= GPL_RESET;
		end else if (cfg_write) begin
			gpl_q <= cfg_data;
		end
	end

	// pending bytes and line position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 16'd0;
			cnt_q  <= 2'd0;
			gil_q  <= 8'd0;
		end else if (accept) begin
			if (message_last) begin
				pend_q <= 16'd0;
				cnt_q  <= 2'd0;
				gil_q  <= 8'd0;
			end else if (full_grp) begin
				pend_q <= 16'd0;
				cnt_q  <= 2'd0;
				gil_q  <= gil_after;
			end else begin
				if (cnt_q == 2'd0) begin
					pend_q <= {data_byte, 8'd0};
				end else begin
					pend_q <= {pend_q[15:8], data_byte};
				end
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/b64lw_queue.sv
// Small job queue between front and back end, built from registers.
// Depends on b64lw_pkg for the job type.
`default_nettype none

module b64lw_queue
	import b64lw_pkg::*;
#(
	parameter int unsigned DEPTH = 2
)(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output job_t      head_job
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	job_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slots_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/b64lw_back.sv
// Back end: walks each job one character per cycle into the output register while not stalled.
// Depends on b64lw_pkg.
`default_nettype none

module b64lw_back
	import b64lw_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       head_valid,
	input  job_t            head_job,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [6:0]      out_char,
	output logic            run_last,
	output logic            message_end
);

	logic       out_valid_q;
	logic [6:0] out_char_q;
	logic       run_last_q;
	logic       message_end_q;
	logic [2:0] slot_q;

	logic       load;
	logic       final_char;
	logic [6:0] sel_char;

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign run_last    = run_last_q;
	assign message_end = message_end_q;

	// character select for the current slot
	always_comb begin
		case (slot_q)
			SLOT_CR: sel_char = CHAR_CR;
			SLOT_LF: sel_char = CHAR_LF;
			default: sel_char = head_job.chars[slot_q[1:0]];
		endcase
		final_char = ((slot_q == SLOT_G3) && !head_job.newline) || (slot_q == SLOT_LF);
		load       = head_valid && (!out_valid_q || !out_stall);
		pop        = load && final_char;
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q    <= sel_char;
			run_last_q    <= final_char;
			message_end_q <= final_char && head_job.msg_last;
		end
	end

	// output valid and slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			slot_q      <= SLOT_FIRST;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				slot_q      <= final_char ? SLOT_FIRST : slot_q + 3'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/base64_line_wrapped_encoder.sv
// Line-wrapped base64 encoder: byte input channel, character output channel.
//
// Input: one message byte per beat (data_byte, message_last) on in_valid/in_stall.
// Output: one ASCII character per beat (out_char, run_last, message_end) on
// out_valid/out_stall. Every third byte, or the byte marked last, yields a
// four-character group; CR LF follows a full line and closes each message.
// run_last marks the last character caused by one input byte, message_end
// the final character of a message.
// Path: a group's job enters the queue at the edge that accepts its byte, then
// its characters go to the output register, after any earlier jobs.
// Throughput: one character per cycle at the output register while the receiver
// does not stall; a group has four characters, six with a line break. The job
// queue (QUEUE_DEPTH groups) lets the front take bytes while the back end
// drains characters.
// Line length is set by cfg_write/cfg_data (groups per line, 0 acts as 1) and
// must be written while idle by the user; the block does not enforce it. Reset
// clears pending bytes, line position and queue and sets 18 groups per line.
// When the receiver stalls, the output beat holds; in_stall rises on a full queue.
// Depends on b64lw_pkg, b64lw_front, b64lw_queue, b64lw_back.
`default_nettype none

module base64_line_wrapped_encoder
	import b64lw_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
)(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       message_last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [6:0]      out_char,
	output logic            run_last,
	output logic            message_end
);

	logic push;
	job_t push_job;
	logic q_full;
	logic pop;
	logic head_valid;
	job_t head_job;

	// byte intake and group building
	b64lw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.message_last (message_last),
		.q_full       (q_full),
		.push         (push),
		.push_job     (push_job)
	);

	// job queue
	b64lw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// character output
	b64lw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.run_last    (run_last),
		.message_end (message_end)
	);

endmodule

`default_nettype wire
